// ----- rtl/systematic_weight_resampler_defines.svh -----
// assertion macros shared by the resampler rtl
// no dependencies; included by the files that assert
`ifndef SYSTEMATIC_WEIGHT_RESAMPLER_DEFINES_SVH
`define SYSTEMATIC_WEIGHT_RESAMPLER_DEFINES_SVH

// condition must never hold outside reset
`define SWR_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

// antecedent implies consequent in the next cycle
`define SWR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/swr_pkg.sv -----
// shared widths, types and constants of the resampler
// no dependencies
package swr_pkg;

  localparam int WEIGHT_W = 27;
  localparam int LABEL_W  = 16;
  localparam int SUM_W    = 48;
  localparam int CNT_W    = 7;

  localparam logic [CNT_W-1:0] OUT_CNT_RESET = CNT_W'(64);

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_CHECK,
    BK_MUL,
    BK_CMP,
    BK_READ,
    BK_EMIT,
    BK_ERR
  } bk_state_t;

endpackage

// ----- rtl/swr_ifs.sv -----
// request channel interfaces of the resampler: entries, results, configuration
// depends on swr_pkg
interface swr_in_if import swr_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [WEIGHT_W-1:0] weight;
  logic [LABEL_W-1:0]  entry_label;
  logic                last_entry;

  modport source (output valid, weight, entry_label, last_entry, input ready);
  modport sink   (input valid, weight, entry_label, last_entry, output ready);
endinterface

interface swr_out_if import swr_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [LABEL_W-1:0] chosen_label;
  logic               last_result;
  logic               norm_error;

  modport source (output valid, chosen_label, last_result, norm_error, input ready);
  modport sink   (input valid, chosen_label, last_result, norm_error, output ready);
endinterface

interface swr_cfg_if import swr_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ----- rtl/swr_ram.sv -----
// generic single write, single read ram with registered read data
// no dependencies
module swr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/swr_fifo.sv -----
// short request queue between the load front and the resampling back
// no dependencies
module swr_fifo #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty,
  output logic             full
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] data_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign empty   = (count_r == '0);
  assign full    = (count_r == CW'(DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = data_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      data_r[wr_ptr_r] <= din;
    end
  end

endmodule

// ----- rtl/swr_front.sv -----
// load front: takes entry requests, keeps the saturating running sum,
// writes the stores and queues a resampling job on the last entry; uses swr_pkg
`include "systematic_weight_resampler_defines.svh"

module swr_front import swr_pkg::*; #(
  parameter int MAX_ENTRIES = 1024
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  swr_in_if.sink                                      in_ch,
  input  logic                                        hold,
  output logic                                        wr_en,
  output logic [$clog2(MAX_ENTRIES)-1:0]              wr_addr,
  output logic [SUM_W-1:0]                            wr_cum,
  output logic [LABEL_W-1:0]                          wr_label,
  output logic                                        job_push,
  output logic [$clog2(MAX_ENTRIES+1)+SUM_W-1:0]      job_data
);

  localparam int AW = $clog2(MAX_ENTRIES);
  localparam int NW = $clog2(MAX_ENTRIES + 1);

  logic [NW-1:0]    entry_count_r, entry_count_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [SUM_W:0]   sum_ext;
  logic [SUM_W-1:0] sum_sat;
  logic             accept, store_full;
  logic [NW-1:0]    n_fin;
  logic [SUM_W-1:0] sum_fin;

  assign in_ch.ready = !hold;
  assign accept      = in_ch.valid && in_ch.ready;
  assign store_full  = (entry_count_r == NW'(MAX_ENTRIES));

  assign sum_ext = {1'b0, sum_r} + (SUM_W + 1)'(in_ch.weight);
  assign sum_sat = sum_ext[SUM_W] ? {SUM_W{1'b1}} : sum_ext[SUM_W-1:0];

  assign wr_en    = accept && !store_full;
  assign wr_addr  = entry_count_r[AW-1:0];
  assign wr_cum   = sum_sat;
  assign wr_label = in_ch.entry_label;

  assign n_fin    = store_full ? entry_count_r : entry_count_r + NW'(1);
  assign sum_fin  = store_full ? sum_r : sum_sat;
  assign job_push = accept && in_ch.last_entry;
  assign job_data = {n_fin, sum_fin};

  always_comb begin
    entry_count_nxt = entry_count_r;
    sum_nxt         = sum_r;
    if (job_push) begin
      entry_count_nxt = '0;
      sum_nxt         = '0;
    end else if (wr_en) begin
      entry_count_nxt = entry_count_r + NW'(1);
      sum_nxt         = sum_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_count_r <= '0;
      sum_r         <= '0;
    end else begin
      entry_count_r <= entry_count_nxt;
      sum_r         <= sum_nxt;
    end
  end

  `SWR_ASSERT_NEVER(a_count_bound, clk, rst_n, entry_count_r > NW'(MAX_ENTRIES), "entry count overrun")

endmodule

// ----- rtl/swr_back.sv -----
// resampling back: normalisation check and merge walk over the stored sums,
// emits labels through an output register; uses swr_pkg
`include "systematic_weight_resampler_defines.svh"

module swr_back import swr_pkg::*; #(
  parameter int MAX_ENTRIES = 1024,
  parameter int MAX_OUTPUTS = 64,
  parameter int FRAC_BITS   = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   job_valid,
  input  logic [$clog2(MAX_ENTRIES+1)+SUM_W-1:0] job_data,
  output logic                                   job_pop,
  input  logic [CNT_W-1:0]                       output_count,
  output logic [$clog2(MAX_ENTRIES)-1:0]         rd_addr,
  input  logic [SUM_W-1:0]                       rd_cum,
  input  logic [LABEL_W-1:0]                     rd_label,
  output logic                                   busy,
  swr_out_if.source                              out_ch
);

  localparam int AW     = $clog2(MAX_ENTRIES);
  localparam int NW     = $clog2(MAX_ENTRIES + 1);
  localparam int PROD_W = SUM_W + CNT_W;

  bk_state_t          state_r, state_nxt;
  logic [NW-1:0]      n_r, n_nxt;
  logic [SUM_W-1:0]   sum_r, sum_nxt;
  logic [SUM_W-1:0]   limit_r, limit_nxt, limit_c;
  logic [PROD_W-1:0]  pos_r, pos_nxt, prod_r, prod_nxt;
  logic [AW-1:0]      j_r, j_nxt;
  logic [CNT_W-1:0]   i_r, i_nxt, m_r, m_nxt, m_clamp, m_plus1;
  logic               out_valid_r, out_valid_nxt;
  logic [LABEL_W-1:0] out_label_r, out_label_nxt;
  logic               out_last_r, out_last_nxt;
  logic               out_err_r, out_err_nxt;
  logic               slot_free, norm_bad, advance;

  assign slot_free = !out_valid_r || out_ch.ready;
  assign limit_c   = SUM_W'(n_r) << FRAC_BITS;
  assign norm_bad  = (n_r == '0) || (sum_r > limit_c);
  assign advance   = ((NW'(j_r) + NW'(1)) < n_r) && (pos_r > prod_r);
  assign m_plus1   = m_r + CNT_W'(1);

  always_comb begin
    if (output_count == '0) begin
      m_clamp = CNT_W'(1);
    end else if (output_count > CNT_W'(MAX_OUTPUTS)) begin
      m_clamp = CNT_W'(MAX_OUTPUTS);
    end else begin
      m_clamp = output_count;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE:  if (job_valid) state_nxt = BK_CHECK;
      BK_CHECK: state_nxt = norm_bad ? BK_ERR : BK_MUL;
      BK_MUL:   state_nxt = BK_CMP;
      BK_CMP:   state_nxt = advance ? BK_READ : BK_EMIT;
      BK_READ:  state_nxt = BK_MUL;
      BK_EMIT: begin
        if (slot_free) begin
          state_nxt = (i_r == m_r) ? BK_IDLE : BK_CMP;
        end
      end
      BK_ERR:   if (slot_free) state_nxt = BK_IDLE;
      default:  state_nxt = BK_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    n_nxt         = n_r;
    sum_nxt       = sum_r;
    limit_nxt     = limit_r;
    pos_nxt       = pos_r;
    prod_nxt      = prod_r;
    j_nxt         = j_r;
    i_nxt         = i_r;
    m_nxt         = m_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_label_nxt = out_label_r;
    out_last_nxt  = out_last_r;
    out_err_nxt   = out_err_r;
    job_pop       = 1'b0;
    unique case (state_r)
      BK_IDLE: begin
        if (job_valid) begin
          job_pop = 1'b1;
          n_nxt   = job_data[NW+SUM_W-1:SUM_W];
          sum_nxt = job_data[SUM_W-1:0];
          j_nxt   = '0;
          i_nxt   = CNT_W'(1);
          m_nxt   = m_clamp;
        end
      end
      BK_CHECK: begin
        limit_nxt = limit_c;
        pos_nxt   = PROD_W'(limit_c);
      end
      BK_MUL: begin
        prod_nxt = PROD_W'(m_plus1) * PROD_W'(rd_cum);
      end
      BK_CMP: begin
        if (advance) begin
          j_nxt = j_r + AW'(1);
        end
      end
      BK_READ: begin
      end
      BK_EMIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_label_nxt = rd_label;
          out_last_nxt  = (i_r == m_r);
          out_err_nxt   = 1'b0;
          i_nxt         = i_r + CNT_W'(1);
          pos_nxt       = pos_r + PROD_W'(limit_r);
        end
      end
      BK_ERR: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_label_nxt = '0;
          out_last_nxt  = 1'b1;
          out_err_nxt   = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r         <= n_nxt;
    sum_r       <= sum_nxt;
    limit_r     <= limit_nxt;
    pos_r       <= pos_nxt;
    prod_r      <= prod_nxt;
    j_r         <= j_nxt;
    i_r         <= i_nxt;
    m_r         <= m_nxt;
    out_label_r <= out_label_nxt;
    out_last_r  <= out_last_nxt;
    out_err_r   <= out_err_nxt;
  end

  assign rd_addr             = j_r;
  assign busy                = (state_r != BK_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.chosen_label = out_label_r;
  assign out_ch.last_result  = out_last_r;
  assign out_ch.norm_error   = out_err_r;

  `SWR_ASSERT_NEVER(a_walk_range, clk, rst_n, (state_r == BK_CMP) && (NW'(j_r) >= n_r), "walk index past loaded entries")
  `SWR_ASSERT_NEXT(a_run_end, clk, rst_n, (state_r == BK_EMIT) && slot_free && (i_r == m_r), (state_r == BK_IDLE) && out_valid_r && out_last_r, "final label not flagged")

endmodule

// ----- rtl/systematic_weight_resampler.sv -----
// top level of the systematic weight resampler
// depends on swr_pkg, swr_ifs, swr_ram, swr_fifo, swr_front, swr_back
`include "systematic_weight_resampler_defines.svh"

// Entries load at one per cycle while no job is queued or running: each
// weight is added to a saturating 48-bit running sum, and the sum and label
// go to two single-port-write rams. The entry marked last queues a job for
// the resampling engine, and no further entry is taken until the engine has
// issued that job's final result to its output register. The engine checks
// normalisation, then runs a merge walk whose step reads one stored sum and
// scales it by the clamped output count plus one in a registered multiplier:
// each entry passed goes through compare, read and multiply states, and each
// label through an emit and a compare state; output stalls hold the emit.
// A normalisation error yields one result with norm_error set. Results sit in
// an output register, so the walk continues while one label awaits its taker.
module systematic_weight_resampler import swr_pkg::*; #(
  parameter int MAX_ENTRIES = 1024,
  parameter int MAX_OUTPUTS = 64,
  parameter int FRAC_BITS   = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  swr_in_if.sink     in_ch,
  swr_out_if.source  out_ch,
  swr_cfg_if.sink    cfg_ch
);

  localparam int AW    = $clog2(MAX_ENTRIES);
  localparam int NW    = $clog2(MAX_ENTRIES + 1);
  localparam int JOB_W = NW + SUM_W;

  logic [CNT_W-1:0]   output_count_r, output_count_nxt;
  logic               wr_en;
  logic [AW-1:0]      wr_addr, rd_addr;
  logic [SUM_W-1:0]   wr_cum, rd_cum;
  logic [LABEL_W-1:0] wr_label, rd_label;
  logic               job_push, job_pop, job_empty, job_full;
  logic [JOB_W-1:0]   job_in, job_out;
  logic               back_busy, hold;

  assign cfg_ch.ready     = 1'b1;
  assign output_count_nxt = (cfg_ch.valid && cfg_ch.ready) ? cfg_ch.data : output_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      output_count_r <= OUT_CNT_RESET;
    end else begin
      output_count_r <= output_count_nxt;
    end
  end

  assign hold = !job_empty || back_busy;

  swr_front #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .hold     (hold),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_cum   (wr_cum),
    .wr_label (wr_label),
    .job_push (job_push),
    .job_data (job_in)
  );

  swr_ram #(
    .WIDTH (SUM_W),
    .DEPTH (MAX_ENTRIES)
  ) u_cum_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_cum),
    .raddr (rd_addr),
    .rdata (rd_cum)
  );

  swr_ram #(
    .WIDTH (LABEL_W),
    .DEPTH (MAX_ENTRIES)
  ) u_label_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_label),
    .raddr (rd_addr),
    .rdata (rd_label)
  );

  swr_fifo #(
    .WIDTH (JOB_W),
    .DEPTH (2)
  ) u_job_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (job_push),
    .din   (job_in),
    .pop   (job_pop),
    .dout  (job_out),
    .empty (job_empty),
    .full  (job_full)
  );

  swr_back #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .MAX_OUTPUTS (MAX_OUTPUTS),
    .FRAC_BITS   (FRAC_BITS)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .job_valid    (!job_empty),
    .job_data     (job_out),
    .job_pop      (job_pop),
    .output_count (output_count_r),
    .rd_addr      (rd_addr),
    .rd_cum       (rd_cum),
    .rd_label     (rd_label),
    .busy         (back_busy),
    .out_ch       (out_ch)
  );

  `SWR_ASSERT_NEVER(a_no_wr_in_walk, clk, rst_n, wr_en && back_busy, "store written during resampling")
  `SWR_ASSERT_NEVER(a_job_q_bound, clk, rst_n, job_push && job_full, "job queue overflow")

endmodule
